/* hw/rtl/unsorted_set_table_assert.svh */
// Assertion macros used by the port-level checker of the set table.
`ifndef UNSORTED_SET_TABLE_ASSERT_SVH
`define UNSORTED_SET_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UST_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("set table assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define UST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("set table assertion failed");

`endif

/* hw/rtl/ust_pkg.sv */
// Package with sizes, codes and types of the unsorted set table.
package ust_pkg;

	// Table capacity and the widths that follow from it.
	localparam int CAPACITY = 32;
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int DATA_W = 32;

	// Command codes; the unused code falls to the default arm.
	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_DELETE = 2'd2
	} ust_cmd_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_PRESENT  = 3'd1,
		ST_FULL     = 3'd2,
		ST_FOUND    = 3'd3,
		ST_ABSENT   = 3'd4,
		ST_DELETED  = 3'd5
	} ust_status_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_SHIFT,
		S_FINISH
	} ust_state_t;

	// One write port and one read address into the element store.
	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [DATA_W-1:0] wdata;
		logic [IDX_W-1:0]  raddr;
	} ust_mem_req_t;

endpackage

/* hw/rtl/unsorted_set_table.sv */
// Top level of the unsorted set table: sequencer, compare unit and result register.
//
//   channel   handshake             fields
//   request   cmd_valid/cmd_stall   command[1:0], value[31:0] signed
//   result    res_valid/res_stall   status[2:0], position[4:0], entry_count[5:0]
//
// A request is taken only while idle; one store read per cycle. Search scans the entries
// from the first until a hit or the end; a delete then shifts the later entries down one
// place, and a finish state passes the result to the result register.
// Reset clears the count and all control state; the store itself is not cleared.
// A result waits in its register under res_stall while the next request is taken.
module unsorted_set_table
	import ust_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [1:0]         command,
	input  logic signed [31:0] value,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [2:0]         status,
	output logic [4:0]         position,
	output logic [5:0]         entry_count
);

	ust_state_t        state_q, state_d;
	ust_mem_req_t      mem_req;
	logic [DATA_W-1:0] rd_data;

	logic [1:0]        command_q;
	logic [DATA_W-1:0] value_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  k_q;
	logic              pend_q;
	logic [IDX_W-1:0]  pidx_q;
	ust_status_t       res_status_q;
	logic [IDX_W-1:0]  res_pos_q;

	logic              res_valid_q;
	logic [2:0]        status_q;
	logic [4:0]        position_q;
	logic [5:0]        entry_count_q;

	logic              accept;
	logic              issue;
	logic              hit;
	logic              scan_end;
	logic              full;
	logic              out_free;
	logic [IDX_W+4:0]  pos_wide;
	logic [CNT_W+5:0]  cnt_wide;

	ust_store u_store (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	// Shared compare unit and scan control.
	always_comb begin
		accept   = cmd_valid && !cmd_stall;
		issue    = (k_q < count_q);
		hit      = pend_q && (rd_data == value_q);
		scan_end = !pend_q && !issue;
		full     = (count_q == CNT_W'(CAPACITY));
		out_free = !res_valid_q || !res_stall;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (hit && command_q == CMD_DELETE) begin
					state_d = S_SHIFT;
				end else if (hit || scan_end) begin
					state_d = S_FINISH;
				end
			end
			S_SHIFT: begin
				if (scan_end) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs of the sequencer: request stall and store port.
	always_comb begin
		cmd_stall     = (state_q != S_IDLE);
		mem_req.we    = 1'b0;
		mem_req.waddr = count_q[IDX_W-1:0];
		mem_req.wdata = value_q;
		mem_req.raddr = k_q[IDX_W-1:0];
		case (state_q)
			S_SEARCH: begin
				if (scan_end && command_q == CMD_INSERT && !full) begin
					mem_req.we = 1'b1;
				end
			end
			S_SHIFT: begin
				// Each entry read above the hole moves down one place.
				if (pend_q) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = pidx_q - IDX_W'(1);
					mem_req.wdata = rd_data;
				end
			end
			default: mem_req.we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Scan counters, entry count and the pending result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			k_q     <= '0;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					k_q    <= '0;
					pend_q <= 1'b0;
				end
				S_SEARCH: begin
					if (hit) begin
						pend_q <= 1'b0;
						k_q    <= CNT_W'(pidx_q) + CNT_W'(1);
					end else if (scan_end) begin
						pend_q <= 1'b0;
						if (command_q == CMD_INSERT && !full) begin
							count_q <= count_q + CNT_W'(1);
						end
					end else begin
						pend_q <= issue;
						if (issue) begin
							k_q <= k_q + CNT_W'(1);
						end
					end
				end
				S_SHIFT: begin
					pend_q <= issue;
					if (issue) begin
						k_q <= k_q + CNT_W'(1);
					end
					if (scan_end) begin
						count_q <= count_q - CNT_W'(1);
					end
				end
				default: pend_q <= 1'b0;
			endcase
		end
	end

	// Request payload, read index in flight and the decided status.
	always_ff @(posedge clk) begin
		if (accept) begin
			command_q <= command;
			value_q   <= value;
		end
		if (state_q == S_SEARCH || state_q == S_SHIFT) begin
			pidx_q <= k_q[IDX_W-1:0];
		end
		if (state_q == S_SEARCH && (hit || scan_end)) begin
			res_status_q <= ST_ABSENT;
			res_pos_q    <= '0;
			case (command_q)
				CMD_INSERT: begin
					if (hit) begin
						res_status_q <= ST_PRESENT;
						res_pos_q    <= pidx_q;
					end else if (full) begin
						res_status_q <= ST_FULL;
					end else begin
						res_status_q <= ST_INSERTED;
						res_pos_q    <= count_q[IDX_W-1:0];
					end
				end
				CMD_LOOKUP: begin
					if (hit) begin
						res_status_q <= ST_FOUND;
						res_pos_q    <= pidx_q;
					end
				end
				CMD_DELETE: begin
					if (hit) begin
						res_status_q <= ST_DELETED;
						res_pos_q    <= pidx_q;
					end
				end
				default: res_status_q <= ST_ABSENT;
			endcase
		end
	end

	// Result fields masked to the port widths.
	assign pos_wide = {5'd0, res_pos_q};
	assign cnt_wide = {6'd0, count_q};

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_FINISH && out_free) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && out_free) begin
			status_q      <= res_status_q;
			position_q    <= pos_wide[4:0];
			entry_count_q <= cnt_wide[5:0];
		end
	end

	assign res_valid   = res_valid_q;
	assign status      = status_q;
	assign position    = position_q;
	assign entry_count = entry_count_q;

endmodule

/* hw/rtl/ust_store.sv */
// Element store: one write port and one registered read port.
module ust_store
	import ust_pkg::*;
(
	input  logic              clk,
	input  ust_mem_req_t      req,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [CAPACITY];
	logic [DATA_W-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	// Read port with registered data.
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[req.raddr];
	end

	assign rd_data = rd_data_q;

endmodule

/* hw/rtl/ust_checker.sv */
// Port-level checker of the unsorted set table and its bind.
`include "unsorted_set_table_assert.svh"

module ust_checker
	import ust_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_stall,
	input logic [1:0]  command,
	input logic [31:0] value,
	input logic        res_valid,
	input logic        res_stall,
	input logic [2:0]  status,
	input logic [4:0]  position,
	input logic [5:0]  entry_count
);

	logic [5:0] full_count;
	assign full_count = 6'(CAPACITY);

	// The block is busy in the cycle after it takes a request.
	`UST_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, cmd_valid && !cmd_stall, cmd_stall)
	// A stalled result keeps its status.
	`UST_ASSERT_NEXT(a_result_held, clk, arst_n, res_valid && res_stall, res_valid && $stable(status))
	// An insert lands at the last place of the grown table.
	`UST_ASSERT_NOW(a_insert_at_end, clk, arst_n, res_valid && status == ST_INSERTED, {1'b0, position} == entry_count - 6'd1)
	// A full report leaves the table at capacity with position zero.
	`UST_ASSERT_NOW(a_full_report, clk, arst_n, res_valid && status == ST_FULL, position == 5'd0 && entry_count == full_count)

endmodule

bind unsorted_set_table ust_checker u_ust_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd_valid),
	.cmd_stall   (cmd_stall),
	.command     (command),
	.value       (value),
	.res_valid   (res_valid),
	.res_stall   (res_stall),
	.status      (status),
	.position    (position),
	.entry_count (entry_count)
);

/* tb/sv/unsorted_set_table_checker.sv */
// Checker for the unsorted set table: predicts each result and compares it with the block.
`timescale 1ns / 100ps

module unsorted_set_table_checker
	import ust_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  logic               cmd_stall,
	input  logic [1:0]         command,
	input  logic signed [31:0] value,
	input  logic               res_valid,
	input  logic               res_stall,
	input  logic [2:0]         status,
	input  logic [4:0]         position,
	input  logic [5:0]         entry_count,
	output int                 fail_count,
	output int                 pending_results
);

	// One predicted result of a request.
	typedef struct packed {
		ust_status_t status;
		logic [4:0]  position;
		logic [5:0]  count;
	} set_result_t;

	// Shadow copy of the set and the results still to come.
	logic [DATA_W-1:0] set_vals [CAPACITY];
	int                set_count;
	set_result_t       awaited_results [$];
	int                errors;

	// Apply one request to the shadow set and return the result it gives.
	function automatic set_result_t apply_command(input logic [1:0] cmd,
			input logic [31:0] val);
		set_result_t r;
		int          hit;
		hit = -1;
		for (int k = 0; k < set_count; k++)
			if (hit < 0 && set_vals[k] == val)
				hit = k;
		r.status = ST_ABSENT;
		r.position = '0;
		case (cmd)
			CMD_INSERT: begin
				if (hit >= 0) begin
					r.status = ST_PRESENT;
					r.position = hit[4:0];
				end else if (set_count >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					set_vals[set_count] = val;
					r.position = set_count[4:0];
					set_count++;
					r.status = ST_INSERTED;
				end
			end
			CMD_LOOKUP: begin
				if (hit >= 0) begin
					r.status = ST_FOUND;
					r.position = hit[4:0];
				end
			end
			CMD_DELETE: begin
				// Later entries move down one place so the order is kept.
				if (hit >= 0) begin
					for (int k = hit; k + 1 < set_count; k++)
						set_vals[k] = set_vals[k + 1];
					set_count--;
					r.status = ST_DELETED;
					r.position = hit[4:0];
				end
			end
			default: begin
			end
		endcase
		r.count = set_count[5:0];
		return r;
	endfunction

	// Watch both channels; a result is matched before this edge's request is added.
	always @(posedge clk or negedge arst_n) begin : watch
		set_result_t want;
		if (!arst_n) begin
			awaited_results.delete();
			set_count = 0;
			errors = 0;
			fail_count <= 0;
			pending_results <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (awaited_results.size() == 0) begin
					errors++;
					$error("result with no request outstanding: status %0d position %0d count %0d",
						status, position, entry_count);
				end else begin
					want = awaited_results.pop_front();
					if (status !== want.status) begin
						errors++;
						$error("status: expected %0d, got %0d", want.status, status);
					end
					if (position !== want.position) begin
						errors++;
						$error("position: expected %0d, got %0d", want.position, position);
					end
					if (entry_count !== want.count) begin
						errors++;
						$error("entry_count: expected %0d, got %0d", want.count, entry_count);
					end
				end
			end
			if (cmd_valid && !cmd_stall)
				awaited_results.push_back(apply_command(command, value));
			fail_count <= errors;
			pending_results <= awaited_results.size();
		end
	end

endmodule

/* tb/sv/unsorted_set_table_tb.sv */
// Testbench top of the unsorted set table: clock, reset, request stimulus, result stalls, verdict.
`timescale 1ns / 100ps

module unsorted_set_table_tb;
	import ust_pkg::*;

	// The command code that the block does not use.
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int POOL_SIZE = 48;
	localparam int ROUNDS = 6;
	localparam int ROUND_ITEMS = 100;
	localparam int HOLD_AT = 3000;
	localparam int HOLD_LEN = 400;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cmd_valid;
	logic               cmd_stall;
	logic [1:0]         command;
	logic signed [31:0] value;
	logic               res_valid;
	logic               res_stall;
	logic [2:0]         status;
	logic [4:0]         position;
	logic [5:0]         entry_count;
	int                 fail_count;
	int                 pending_results;

	logic [31:0] value_pool [POOL_SIZE];
	int          burst_left;

	unsorted_set_table uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.command(command),
		.value(value),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.status(status),
		.position(position),
		.entry_count(entry_count)
	);

	unsorted_set_table_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.command(command),
		.value(value),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.status(status),
		.position(position),
		.entry_count(entry_count),
		.fail_count(fail_count),
		.pending_results(pending_results)
	);

	// 4 ns clock.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Offer one request and hold it until the block takes it; bursts end in random gaps.
	task automatic send_request(input logic [1:0] cmd, input logic [31:0] val);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		command <= cmd;
		value <= val;
		cmd_valid <= 1'b1;
		do
			@(posedge clk);
		while (cmd_stall);
	endtask

	// Mostly values from the pool so that hits are common; sometimes any value.
	function automatic logic [31:0] pick_value();
		if ($urandom_range(0, 99) < 15)
			return $urandom;
		return value_pool[$urandom_range(0, POOL_SIZE - 1)];
	endfunction

	// Request stimulus and the verdict.
	initial begin
		int pick;
		int mode;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		command = CMD_INSERT;
		value = '0;
		burst_left = 0;
		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7FFF_FFFF;
		value_pool[2] = 32'h0000_0000;
		value_pool[3] = 32'hFFFF_FFFF;
		for (int k = 4; k < POOL_SIZE; k++)
			value_pool[k] = $urandom;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty table, extremes, duplicates, shifts and the unused code.
		send_request(CMD_LOOKUP, 32'd5);
		send_request(CMD_DELETE, 32'd5);
		send_request(CMD_UNUSED, 32'd5);
		send_request(CMD_INSERT, 32'h8000_0000);
		send_request(CMD_INSERT, 32'h7FFF_FFFF);
		send_request(CMD_INSERT, 32'h0000_0000);
		send_request(CMD_INSERT, 32'hFFFF_FFFF);
		send_request(CMD_INSERT, 32'h0000_0001);
		send_request(CMD_INSERT, 32'hAAAA_AAAA);
		send_request(CMD_INSERT, 32'h5555_5555);
		send_request(CMD_INSERT, 32'h7FFF_FFFF);
		send_request(CMD_LOOKUP, 32'h8000_0000);
		send_request(CMD_LOOKUP, 32'hFFFF_FFFF);
		send_request(CMD_LOOKUP, 32'h1234_5678);
		send_request(CMD_DELETE, 32'h0000_0000);
		send_request(CMD_LOOKUP, 32'hFFFF_FFFF);
		send_request(CMD_DELETE, 32'h8000_0000);
		send_request(CMD_DELETE, 32'h5555_5555);
		send_request(CMD_DELETE, 32'h5555_5555);
		send_request(CMD_UNUSED, 32'h7FFF_FFFF);
		send_request(CMD_INSERT, 32'h8000_0000);

		// Random part: rounds that fill the table, churn it and drain it.
		for (int round = 0; round < ROUNDS; round++) begin
			mode = round % 3;
			for (int n = 0; n < ROUND_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 4)
					send_request(CMD_UNUSED, $urandom);
				else if (mode == 0)
					send_request((pick < 78) ? CMD_INSERT :
						(pick < 93) ? CMD_LOOKUP : CMD_DELETE, pick_value());
				else if (mode == 1)
					send_request((pick < 36) ? CMD_INSERT :
						(pick < 68) ? CMD_LOOKUP : CMD_DELETE, pick_value());
				else
					send_request((pick < 19) ? CMD_INSERT :
						(pick < 34) ? CMD_LOOKUP : CMD_DELETE, pick_value());
			end
		end
		cmd_valid <= 1'b0;

		// Drain the outstanding results, then let the block settle.
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (2 * CAPACITY + 8) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Result stalls: modes that change now and then, and one long hold-off.
	initial begin
		int cycle;
		int hold_left;
		int stall_mode;
		int mode_left;
		res_stall = 1'b0;
		cycle = 0;
		hold_left = 0;
		mode_left = 0;
		stall_mode = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			cycle++;
			if (cycle == HOLD_AT)
				hold_left = HOLD_LEN;
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(50, 200);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else begin
				case (stall_mode)
					0: res_stall <= 1'b0;
					1: res_stall <= ($urandom_range(0, 2) == 0);
					2: res_stall <= ($urandom_range(0, 3) != 0);
					default: res_stall <= (cycle % 3 == 0);
				endcase
			end
		end
	end

	// Watchdog for a hung run.
	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
